// ===== design/response_frame_crc_checker_core_defines.svh =====
// ----------------------------------------------------------------------------
// Response frame CRC checker assertion macros
// Concurrent assertion forms used by the rfcc_frame module.
// ----------------------------------------------------------------------------
`ifndef RESPONSE_FRAME_CRC_CHECKER_CORE_DEFINES_SVH
`define RESPONSE_FRAME_CRC_CHECKER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RFCC_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("rfcc assertion failed");

// next-cycle implication, checked out of reset
`define RFCC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("rfcc assertion failed");

`endif

// ===== design/rfcc_pkg.sv =====
// ----------------------------------------------------------------------------
// Response frame CRC checker package
// Types, constants and the bytewise CRC-16 step shared by the rfcc modules.
// ----------------------------------------------------------------------------
package rfcc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [7:0]  MIN_LEN  = 8'd3;
    localparam logic [7:0]  CRC_BYTES = 8'd2;

    typedef enum logic [1:0] {
        ST_MATCH    = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_SHORT    = 2'd2
    } t_status;

    typedef struct packed {
        t_status     status;
        logic [15:0] crc;
        logic [7:0]  len;
    } t_result;

    typedef struct packed {
        logic proc;
        logic res_valid;
    } t_frame_ctl;

    // data bits enter LSB first, register shifts toward MSB
    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            if (b[i] != c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== design/rfcc_in_reg.sv =====
// ----------------------------------------------------------------------------
// Response frame CRC checker input register
// Holds one request byte until the frame stage consumes it.
// ----------------------------------------------------------------------------
module rfcc_in_reg (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_proc,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       accept;

    assign o_in_stall = r_valid && !i_proc;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        if (accept) begin
            n_valid = 1'b1;
        end else if (i_proc) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_data_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

// ===== design/rfcc_frame.sv =====
// ----------------------------------------------------------------------------
// Response frame CRC checker frame stage
// Tracks position in the frame, runs the CRC and forms the per-frame result.
// ----------------------------------------------------------------------------
`include "response_frame_crc_checker_core_defines.svh"

module rfcc_frame (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [7:0]          i_byte,
    input  logic                i_out_free,
    output rfcc_pkg::t_frame_ctl o_ctl,
    output rfcc_pkg::t_result   o_result
);
    import rfcc_pkg::*;

    logic [15:0] r_crc;
    logic [15:0] n_crc;
    logic [7:0]  r_pos;
    logic [7:0]  n_pos;
    logic [7:0]  r_len;
    logic [7:0]  n_len;
    logic [7:0]  r_crc_lo;
    logic [7:0]  n_crc_lo;
    logic [7:0]  len_m2;
    logic        res_valid;
    logic        proc;
    t_result     result;

    assign len_m2 = r_len - CRC_BYTES;

    always_comb begin
        n_crc       = r_crc;
        n_pos       = r_pos;
        n_len       = r_len;
        n_crc_lo    = r_crc_lo;
        res_valid   = 1'b0;
        result.status = ST_MATCH;
        result.crc    = r_crc;
        result.len    = r_len;
        if (r_pos == 8'd0) begin
            if (i_byte < MIN_LEN) begin
                res_valid     = 1'b1;
                result.status = ST_SHORT;
                result.crc    = 16'd0;
                result.len    = i_byte;
                n_crc         = 16'd0;
                n_len         = 8'd0;
                n_crc_lo      = 8'd0;
            end else begin
                n_len = i_byte;
                n_crc = crc_feed(16'd0, i_byte);
                n_pos = 8'd1;
            end
        end else if (r_pos < len_m2) begin
            n_crc = crc_feed(r_crc, i_byte);
            n_pos = r_pos + 8'd1;
        end else if (r_pos == len_m2) begin
            n_crc_lo = i_byte;
            n_pos    = r_pos + 8'd1;
        end else begin
            res_valid = 1'b1;
            if ((r_crc_lo == r_crc[7:0]) && (i_byte == r_crc[15:8])) begin
                result.status = ST_MATCH;
            end else begin
                result.status = ST_MISMATCH;
            end
            n_crc    = 16'd0;
            n_pos    = 8'd0;
            n_len    = 8'd0;
            n_crc_lo = 8'd0;
        end
    end

    assign proc = i_valid && (!res_valid || i_out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc    <= 16'd0;
            r_pos    <= 8'd0;
            r_len    <= 8'd0;
            r_crc_lo <= 8'd0;
        end else if (proc) begin
            r_crc    <= n_crc;
            r_pos    <= n_pos;
            r_len    <= n_len;
            r_crc_lo <= n_crc_lo;
        end
    end

    assign o_ctl.proc      = proc;
    assign o_ctl.res_valid = res_valid;
    assign o_result        = result;

    `RFCC_ASSERT_IMPL(a_short_zero_crc, res_valid && (result.status == ST_SHORT), result.crc == 16'd0)
    `RFCC_ASSERT_NEXT(a_result_rewinds, proc && res_valid, (r_pos == 8'd0) && (r_crc == 16'd0))
    `RFCC_ASSERT_IMPL(a_open_frame_len, r_pos != 8'd0, (r_len >= MIN_LEN) && (r_pos <= r_len - 8'd1))
endmodule

// ===== design/rfcc_out_reg.sv =====
// ----------------------------------------------------------------------------
// Response frame CRC checker result register
// Holds a frame result until the downstream side takes it.
// ----------------------------------------------------------------------------
module rfcc_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rfcc_pkg::t_frame_ctl i_ctl,
    input  rfcc_pkg::t_result    i_result,
    input  logic                 i_out_stall,
    output logic                 o_free,
    output logic                 o_out_valid,
    output rfcc_pkg::t_result    o_result
);
    import rfcc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;
    logic    load;

    assign o_free = !r_valid || !i_out_stall;
    assign load   = i_ctl.proc && i_ctl.res_valid;

    always_comb begin
        if (load) begin
            n_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_result <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_result;
endmodule

// ===== design/response_frame_crc_checker_core.sv =====
// ----------------------------------------------------------------------------
// Response frame CRC checker core
// Byte-wide frame checker: length byte, body, CRC-16 (0x8005) low byte first.
// ----------------------------------------------------------------------------
// Takes one frame byte per cycle with no gaps required. Each request passes
// an input register, the frame logic (eight CRC bit steps unrolled over the
// byte) and a result register, in that order. A length byte below three
// yields an immediate short-frame result. Input stalls only when a result is
// ready and the result register is held by downstream stall.
module response_frame_crc_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [15:0] o_computed_crc,
    output logic [7:0]  o_frame_length
);
    import rfcc_pkg::*;

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    t_frame_ctl ctl;
    t_result    result;
    t_result    out_result;

    rfcc_in_reg u_in_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_data_byte (i_data_byte),
        .i_proc      (ctl.proc),
        .o_valid     (in_valid),
        .o_byte      (in_byte)
    );

    rfcc_frame u_frame (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_byte     (in_byte),
        .i_out_free (out_free),
        .o_ctl      (ctl),
        .o_result   (result)
    );

    rfcc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_result    (out_result)
    );

    assign o_status       = out_result.status;
    assign o_computed_crc = out_result.crc;
    assign o_frame_length = out_result.len;
endmodule
